// File: rtl/dseb_pkg.sv
package dseb_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CODE = 2'd1,
        ST_UNUSED   = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Request action codes
    localparam logic ACT_SET   = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_GROUPS   = 2'd0;
    localparam logic [1:0] CFG_UNCHANGED = 2'd1;
    localparam logic [1:0] CFG_DURATION = 2'd2;

    // Field widths
    localparam int GROUP_W = 8;
    localparam int CODE_W  = 8;
    localparam int COLOR_W = 8;
    localparam int DUR_W   = 16;
    localparam int TICK_W  = 63;
    localparam int MASK_W  = 64;
    localparam int WORD_W  = GROUP_W + COLOR_W + DUR_W + TICK_W;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_FLUSH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture the request
        logic rd_first;    // read slot 0, clear the walk index
        logic step;        // advance the walk index, read the next slot
        logic wr_en;       // store the request
        logic wr_append;   // store at the fill position instead of the walk index
        logic emit;        // present a result next cycle
        logic emit_entry;  // result carries the slot just read
        logic clear_fill;  // empty the buffer
    } t_dseb_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic action;      // captured action
        logic reject;      // request fails a check
        logic fill_zero;   // buffer empty
        logic match;       // slot just read holds the request's group
        logic at_end;      // slot just read is the last stored one
    } t_dseb_stat;

endpackage

// File: rtl/dseb_ctrl.sv
module dseb_ctrl
    import dseb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dseb_stat i_stat,
    output t_dseb_cmd  o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.action == ACT_FLUSH) begin
                    if (i_stat.fill_zero) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.rd_first = 1'b1;
                        n_state        = S_FLUSH;
                    end
                end else if (i_stat.reject) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_stat.fill_zero) begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_append = 1'b1;
                    o_cmd.emit      = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.match) begin
                    o_cmd.wr_en = 1'b1;
                    o_cmd.emit  = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_stat.at_end) begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_append = 1'b1;
                    o_cmd.emit      = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FLUSH: begin
                o_cmd.emit       = 1'b1;
                o_cmd.emit_entry = 1'b1;
                if (i_stat.at_end) begin
                    o_cmd.clear_fill = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/dseb_datapath.sv
module dseb_datapath
    import dseb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [MASK_W-1:0]   i_cfg_data,
    // request
    input  logic                i_action,
    input  logic [GROUP_W-1:0]  i_group,
    input  logic [CODE_W-1:0]   i_state_code,
    input  logic [COLOR_W-1:0]  i_color,
    input  logic [TICK_W-1:0]   i_take_effect_tick,
    // control
    input  t_dseb_cmd           i_cmd,
    output t_dseb_stat          o_stat,
    // result
    output logic                o_result_valid,
    output logic [1:0]          o_status,
    output logic                o_is_entry,
    output logic [GROUP_W-1:0]  o_entry_group,
    output logic [COLOR_W-1:0]  o_entry_color,
    output logic [DUR_W-1:0]    o_entry_duration,
    output logic [TICK_W-1:0]   o_entry_tick,
    output logic                o_last
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BUFFER_DEPTH);

    // configuration registers
    logic [MASK_W-1:0]  r_cfg_groups;
    logic [CODE_W-1:0]  r_cfg_unchanged;
    logic [DUR_W-1:0]   r_cfg_duration;

    // captured request
    logic               r_req_action;
    logic [GROUP_W-1:0] r_req_group;
    logic [CODE_W-1:0]  r_req_code;
    logic [COLOR_W-1:0] r_req_color;
    logic [TICK_W-1:0]  r_req_tick;

    // buffer state
    logic [CNT_W-1:0]   r_fill;
    logic [IDX_W-1:0]   r_idx;
    logic [WORD_W-1:0]  r_mem [BUFFER_DEPTH];
    logic [WORD_W-1:0]  r_rd_data;

    // result register
    logic               r_out_valid;
    t_status            r_out_status;
    logic               r_out_is_entry;
    logic [GROUP_W-1:0] r_out_group;
    logic [COLOR_W-1:0] r_out_color;
    logic [DUR_W-1:0]   r_out_duration;
    logic [TICK_W-1:0]  r_out_tick;
    logic               r_out_last;

    logic [CNT_W-1:0]   idx_plus;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_word;
    logic [DUR_W-1:0]   wr_duration;
    logic [GROUP_W-1:0] rd_group;
    logic [COLOR_W-1:0] rd_color;
    logic [DUR_W-1:0]   rd_duration;
    logic [TICK_W-1:0]  rd_tick;
    t_status            chk_status;

    // Configuration writes; ready is always high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_groups    <= '0;
            r_cfg_unchanged <= CODE_W'(3);
            r_cfg_duration  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GROUPS:    r_cfg_groups    <= i_cfg_data;
                CFG_UNCHANGED: r_cfg_unchanged <= i_cfg_data[CODE_W-1:0];
                CFG_DURATION:  r_cfg_duration  <= i_cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_action <= i_action;
            r_req_group  <= i_group;
            r_req_code   <= i_state_code;
            r_req_color  <= i_color;
            r_req_tick   <= i_take_effect_tick;
        end
    end

    // Request checks, in priority order
    always_comb begin
        if (r_req_action == ACT_FLUSH) begin
            chk_status = ST_OK;
        end else if (r_req_code > r_cfg_unchanged) begin
            chk_status = ST_BAD_CODE;
        end else if (r_req_group[GROUP_W-1:6] != '0 || !r_cfg_groups[r_req_group[5:0]]) begin
            chk_status = ST_UNUSED;
        end else if (r_fill == FULL_COUNT) begin
            chk_status = ST_FULL;
        end else begin
            chk_status = ST_OK;
        end
    end

    // Slot word fields
    assign rd_group    = r_rd_data[WORD_W-1 -: GROUP_W];
    assign rd_color    = r_rd_data[WORD_W-GROUP_W-1 -: COLOR_W];
    assign rd_duration = r_rd_data[TICK_W +: DUR_W];
    assign rd_tick     = r_rd_data[TICK_W-1:0];

    // Walk addressing
    assign idx_plus    = CNT_W'(r_idx) + CNT_W'(1);
    assign rd_addr     = i_cmd.rd_first ? '0 : IDX_W'(idx_plus);
    assign wr_addr     = i_cmd.wr_append ? IDX_W'(r_fill) : r_idx;
    assign wr_duration = (r_req_code == r_cfg_unchanged) ? '0 : r_cfg_duration;
    assign wr_word     = {r_req_group, r_req_color, wr_duration, r_req_tick};

    // Status to controller
    assign o_stat.action    = r_req_action;
    assign o_stat.reject    = (chk_status != ST_OK);
    assign o_stat.fill_zero = (r_fill == '0);
    assign o_stat.match     = (rd_group == r_req_group);
    assign o_stat.at_end    = (idx_plus == r_fill);

    // Slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_first) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= IDX_W'(idx_plus);
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.clear_fill) begin
            r_fill <= '0;
        end else if (i_cmd.wr_en && i_cmd.wr_append) begin
            r_fill <= r_fill + CNT_W'(1);
        end
    end

    // Result register: strobe for one cycle per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (i_cmd.emit_entry) begin
                r_out_status   <= ST_OK;
                r_out_is_entry <= 1'b1;
                r_out_group    <= rd_group;
                r_out_color    <= rd_color;
                r_out_duration <= rd_duration;
                r_out_tick     <= rd_tick;
                r_out_last     <= o_stat.at_end;
            end else begin
                r_out_status   <= chk_status;
                r_out_is_entry <= 1'b0;
                r_out_group    <= '0;
                r_out_color    <= '0;
                r_out_duration <= '0;
                r_out_tick     <= '0;
                r_out_last     <= 1'b1;
            end
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_status         = r_out_status;
    assign o_is_entry       = r_out_is_entry;
    assign o_entry_group    = r_out_group;
    assign o_entry_color    = r_out_color;
    assign o_entry_duration = r_out_duration;
    assign o_entry_tick     = r_out_tick;
    assign o_last           = r_out_last;

endmodule

// File: rtl/dedup_switch_event_buffer_top.sv
// Timing: a rejected request, or one into an empty buffer, gives its result from the check state
// through the result register; a stored request searches one slot per cycle in the search state.
// Throughput: a flush emits one entry per cycle from the flush state, N results in all, N = fill.
// A new request is taken only while idle, so one request's slot walk ends before the next starts.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset (synchronous, active low) resets control, fill count and configuration, not the slots.
module dedup_switch_event_buffer_top
    import dseb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [MASK_W-1:0]   i_cfg_data,
    // command
    input  logic                start,
    output logic                busy,
    input  logic                i_action,
    input  logic [GROUP_W-1:0]  i_group,
    input  logic [CODE_W-1:0]   i_state_code,
    input  logic [COLOR_W-1:0]  i_color,
    input  logic [TICK_W-1:0]   i_take_effect_tick,
    // result
    output logic                o_result_valid,
    output logic [1:0]          o_status,
    output logic                o_is_entry,
    output logic [GROUP_W-1:0]  o_entry_group,
    output logic [COLOR_W-1:0]  o_entry_color,
    output logic [DUR_W-1:0]    o_entry_duration,
    output logic [TICK_W-1:0]   o_entry_tick,
    output logic                o_last
);

    t_dseb_cmd  cmd;
    t_dseb_stat stat;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    dseb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Slot memory, checks and result register
    dseb_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_action           (i_action),
        .i_group            (i_group),
        .i_state_code       (i_state_code),
        .i_color            (i_color),
        .i_take_effect_tick (i_take_effect_tick),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_result_valid     (o_result_valid),
        .o_status           (o_status),
        .o_is_entry         (o_is_entry),
        .o_entry_group      (o_entry_group),
        .o_entry_color      (o_entry_color),
        .o_entry_duration   (o_entry_duration),
        .o_entry_tick       (o_entry_tick),
        .o_last             (o_last)
    );

endmodule
